FILE: src/sbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants, configuration type and helper functions of the serial
// radio-control frame decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned FrameBytes   = 25;
  localparam int unsigned ChannelCount = 18;
  localparam int unsigned PropChannels = 16;
  localparam int unsigned StoreDepth   = 24;
  localparam int unsigned StoreAddrW   = $clog2(StoreDepth);
  localparam int unsigned ChanW        = 5;
  localparam int unsigned RawW         = 11;
  localparam int unsigned ScaledW      = 12;
  localparam int unsigned OutDataW     = 24;

  localparam logic [StoreAddrW-1:0] FlagByteAddr = StoreAddrW'(23);
  localparam logic [ChanW-1:0]      LastChan     = ChanW'(ChannelCount - 1);
  localparam logic [ChanW-1:0]      FirstDiscChan = ChanW'(PropChannels);

  // floor(x/3) = (x * 2731) >> 13 holds for every x below 4096
  localparam logic [11:0]         Recip3     = 12'd2731;
  localparam int unsigned         RecipShift = 13;
  localparam logic [ScaledW-1:0]  ScaleOffset = 12'd816;

  typedef enum logic [2:0] {
    RegStartByte   = 3'd0,
    RegFsEnable    = 3'd1,
    RegDiscOneMask = 3'd2,
    RegDiscTwoMask = 3'd3,
    RegFsMask      = 3'd4,
    RegDiscHigh    = 3'd5,
    RegDiscLow     = 3'd6
  } sbd_reg_e;

  typedef struct packed {
    logic [7:0]      start_byte;
    logic            failsafe_enable;
    logic [7:0]      discrete_one_mask;
    logic [7:0]      discrete_two_mask;
    logic [7:0]      failsafe_mask;
    logic [RawW-1:0] discrete_high;
    logic [RawW-1:0] discrete_low;
  } sbd_cfg_t;

  localparam sbd_cfg_t CfgReset = '{
    start_byte:        8'd15,
    failsafe_enable:   1'b0,
    discrete_one_mask: 8'd1,
    discrete_two_mask: 8'd2,
    failsafe_mask:     8'd8,
    discrete_high:     11'd2000,
    discrete_low:      11'd1000
  };

  // first bit of a proportional channel in the packed payload: 11 * ch
  function automatic logic [7:0] chan_bitpos(input logic [ChanW-1:0] ch);
    chan_bitpos = {ch, 3'b000} + {2'b00, ch, 1'b0} + {3'b000, ch};
  endfunction

endpackage
`default_nettype wire

FILE: src/sbd_frame_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_frame_ram
// Simple dual-port frame buffer: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module sbd_frame_ram #(
  parameter  int unsigned Depth = 24,
  parameter  int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/sbd_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_regs
// APB-style configuration registers of the frame decoder.
// ----------------------------------------------------------------------------
module sbd_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output sbd_pkg::sbd_cfg_t     cfg_o
);
  import sbd_pkg::*;

  sbd_cfg_t cfg_q;
  sbd_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = sbd_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegStartByte:   cfg_q.start_byte        <= pwdata[7:0];
        RegFsEnable:    cfg_q.failsafe_enable   <= pwdata[0];
        RegDiscOneMask: cfg_q.discrete_one_mask <= pwdata[7:0];
        RegDiscTwoMask: cfg_q.discrete_two_mask <= pwdata[7:0];
        RegFsMask:      cfg_q.failsafe_mask     <= pwdata[7:0];
        RegDiscHigh:    cfg_q.discrete_high     <= pwdata[RawW-1:0];
        RegDiscLow:     cfg_q.discrete_low      <= pwdata[RawW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegStartByte:   prdata[7:0]      = cfg_q.start_byte;
      RegFsEnable:    prdata[0]        = cfg_q.failsafe_enable;
      RegDiscOneMask: prdata[7:0]      = cfg_q.discrete_one_mask;
      RegDiscTwoMask: prdata[7:0]      = cfg_q.discrete_two_mask;
      RegFsMask:      prdata[7:0]      = cfg_q.failsafe_mask;
      RegDiscHigh:    prdata[RawW-1:0] = cfg_q.discrete_high;
      RegDiscLow:     prdata[RawW-1:0] = cfg_q.discrete_low;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: src/sbd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_decode
// Frame sequencer: stores received bytes in the frame buffer, then reads
// them back channel by channel, unpacks, scales and emits the results.
// ----------------------------------------------------------------------------
module sbd_decode (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sbd_pkg::sbd_cfg_t                  cfg_i,
  input  wire logic                               s_tvalid_i,
  input  wire logic [7:0]                         s_tdata_i,
  output logic                                    s_tready_o,
  output logic                                    ram_we_o,
  output logic      [sbd_pkg::StoreAddrW-1:0]     ram_waddr_o,
  output logic      [7:0]                         ram_wdata_o,
  output logic                                    ram_re_o,
  output logic      [sbd_pkg::StoreAddrW-1:0]     ram_raddr_o,
  input  wire logic [7:0]                         ram_rdata_i,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic      [sbd_pkg::OutDataW-1:0]       m_tdata_o,
  output logic      [sbd_pkg::ChanW-1:0]          m_tuser_o,
  output logic                                    m_tlast_o
);
  import sbd_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StFlagRd,
    StFlagWt,
    StFetch,
    StFetchWt,
    StCalc,
    StMul,
    StLoad,
    StHold
  } state_e;

  state_e                state_q;
  logic [4:0]            pos_q;
  logic [ChanW-1:0]      ch_q;
  logic [1:0]            k_q;
  logic                  capture_q;
  logic [23:0]           window_q;
  logic [7:0]            flags_q;
  logic                  fs_clear_q;
  logic [RawW-1:0]       raw_q;
  logic [23:0]           prod_q;
  logic                  m_tvalid_q;
  logic [OutDataW-1:0]   m_tdata_q;
  logic [ChanW-1:0]      m_tuser_q;
  logic                  m_tlast_q;

  logic                  accept;
  logic                  drop;
  logic [7:0]            bitpos;
  logic [StoreAddrW-1:0] base_addr;
  logic [23:0]           win_sh;
  logic                  disc_set;
  logic [RawW-1:0]       raw_d;
  logic [ScaledW-1:0]    scaled;
  logic [ChanW-1:0]      ch_next;

  assign s_tready_o = (state_q == StIdle);
  assign accept     = s_tvalid_i && s_tready_o;
  // outside a frame, drop everything but the start byte
  assign drop       = (pos_q == 5'd0) && (s_tdata_i != cfg_i.start_byte);

  assign ram_we_o    = accept && !drop && (pos_q < 5'(StoreDepth));
  assign ram_waddr_o = pos_q;
  assign ram_wdata_o = s_tdata_i;

  assign bitpos    = chan_bitpos(ch_q);
  assign base_addr = StoreAddrW'(1) + bitpos[7:3];
  assign ram_re_o  = (state_q == StFlagRd) || (state_q == StFetch);
  assign ram_raddr_o = (state_q == StFlagRd) ? FlagByteAddr
                                             : base_addr + {3'b000, k_q};

  assign win_sh   = window_q >> bitpos[2:0];
  assign disc_set = (ch_q == FirstDiscChan) ? |(flags_q & cfg_i.discrete_one_mask)
                                            : |(flags_q & cfg_i.discrete_two_mask);
  assign raw_d    = (ch_q < FirstDiscChan) ? win_sh[RawW-1:0]
                  : (disc_set ? cfg_i.discrete_high : cfg_i.discrete_low);
  assign scaled   = {1'b0, prod_q[23:RecipShift]} + ScaleOffset;
  assign ch_next  = ch_q + ChanW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pos_q      <= '0;
      ch_q       <= '0;
      k_q        <= '0;
      capture_q  <= 1'b0;
      window_q   <= '0;
      flags_q    <= '0;
      fs_clear_q <= 1'b0;
      raw_q      <= '0;
      prod_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= '0;
      m_tlast_q  <= 1'b0;
    end else begin
      capture_q <= (state_q == StFetch);
      if (capture_q) begin
        window_q <= {ram_rdata_i, window_q[23:8]};
      end
      unique case (state_q)
        StIdle: begin
          if (accept && !drop) begin
            if (pos_q == 5'(FrameBytes - 1)) begin
              // final byte closes the frame without being stored
              pos_q   <= '0;
              ch_q    <= '0;
              state_q <= StFlagRd;
            end else begin
              pos_q <= pos_q + 5'd1;
            end
          end
        end
        StFlagRd: state_q <= StFlagWt;
        StFlagWt: begin
          flags_q    <= ram_rdata_i;
          fs_clear_q <= cfg_i.failsafe_enable && ((ram_rdata_i & cfg_i.failsafe_mask) == 8'd0);
          k_q        <= '0;
          state_q    <= StFetch;
        end
        StFetch: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd2) begin
            state_q <= StFetchWt;
          end
        end
        StFetchWt: state_q <= StCalc;
        StCalc: begin
          raw_q   <= raw_d;
          state_q <= StMul;
        end
        StMul: begin
          prod_q  <= {12'd0, raw_q, 1'b0} * {12'd0, Recip3};
          state_q <= StLoad;
        end
        StLoad: begin
          m_tvalid_q <= 1'b1;
          m_tdata_q  <= {fs_clear_q, scaled, raw_q};
          m_tuser_q  <= ch_q;
          m_tlast_q  <= (ch_q == LastChan);
          state_q    <= StHold;
        end
        StHold: begin
          if (m_tready_i) begin
            m_tvalid_q <= 1'b0;
            if (ch_q == LastChan) begin
              state_q <= StIdle;
            end else begin
              ch_q    <= ch_next;
              k_q     <= '0;
              state_q <= (ch_next < FirstDiscChan) ? StFetch : StCalc;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;
  assign m_tlast_o  = m_tlast_q;

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !m_tvalid_o)
    else $error("input accepted while a result is pending");

  a_last_is_final_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tlast_o) |-> (m_tuser_o == LastChan))
    else $error("tlast on a channel other than the last");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 5'(FrameBytes))
    else $error("byte position beyond frame length");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !ram_re_o)
    else $error("frame buffer written during readback");

  a_frame_end_starts_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !drop && pos_q == 5'(FrameBytes - 1)) |=> (state_q == StFlagRd))
    else $error("completed frame did not start decoding");

endmodule
`default_nettype wire

FILE: src/sbus_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial radio-control frame decoder: collects 25-byte frames opened by a
// configurable start byte and emits 18 channel results per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata raw_value/scaled_value/failsafe_clear,
//                       tuser channel_index, tlast last_channel
//  apb       in/out     7 configuration registers at 4*i
//
// Received bytes are taken one per cycle while no frame is being decoded.
// The closing byte starts readback: the flag byte is read first, then each
// proportional channel takes three reads through the single frame buffer read
// port, unpack, multiply and load, and each discrete channel a value select,
// multiply and load. Input tready stays low from the closing byte
// until the last result is taken. Reset returns to waiting for a start byte;
// the frame buffer is not cleared.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [10:0] raw_value, [22:11] scaled_value,
                                           // [23] failsafe_clear
  output logic      [4:0]  m_axis_tuser,   // [4:0] channel_index
  output logic             m_axis_tlast
);
  import sbd_pkg::*;

  sbd_cfg_t              cfg;
  logic                  ram_we;
  logic [StoreAddrW-1:0] ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [StoreAddrW-1:0] ram_raddr;
  logic [7:0]            ram_rdata;

  sbd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbd_frame_ram #(
    .Depth (StoreDepth),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sbd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tdata_i   (s_axis_tdata),
    .s_tready_o  (s_axis_tready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: test/sbus_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb
// Self-checking bench for the serial radio-control frame decoder. Streams
// received bytes (directed frames, random frames, noise and truncated frames)
// through the slave stream under random bursts, predicts the 18 channel
// results of each completed frame, and checks them in order against the master
// stream while the receiver stalls on its own pattern. Covers reset, extreme
// and random register settings over the APB port, with readback.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;
  import sbd_pkg::*;

  localparam int unsigned LimitCycles  = 400000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned NumRegs      = 7;
  localparam int unsigned PhaseBytes   = 10;
  localparam int unsigned PayloadBytes = StoreDepth - 2;

  typedef enum int {FillRandom, FillZero, FillOnes, FillStart} fill_e;

  typedef struct packed {
    logic [ChanW-1:0]   chan;
    logic [RawW-1:0]    raw;
    logic [ScaledW-1:0] scaled;
    logic               fs_clear;
    logic               last;
  } chan_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sbus_frame_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // decoder model state
  sbd_cfg_t     cfg_model = CfgReset;
  logic [7:0]   frame_model [StoreDepth];
  int unsigned  rx_pos = 0;
  chan_result_t pending_channels [$];

  int unsigned mismatches      = 0;
  int unsigned frames_decoded  = 0;
  int unsigned channels_seen   = 0;
  int unsigned bytes_sent      = 0;
  int unsigned settings_tested = 0;
  int unsigned burst_left      = 0;
  int unsigned cycle_count     = 0;
  int unsigned stall_count     = 0;
  int unsigned stall_mode      = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d (after %0d results)",
             what, got, want, channels_seen);
    mismatches++;
  endtask

  function automatic void decode_rx_byte(input logic [7:0] rx);
    logic [8*PayloadBytes-1:0] payload;
    logic [7:0]                flags;
    logic [7:0]                mask;
    logic                      fs;
    chan_result_t              r;
    if (rx_pos == 0 && rx != cfg_model.start_byte) return;
    if (rx_pos < StoreDepth) frame_model[rx_pos] = rx;
    if (rx_pos + 1 < FrameBytes) begin
      rx_pos++;
      return;
    end
    // closing byte: not stored, frame complete
    rx_pos = 0;
    frames_decoded++;
    for (int i = 0; i < PayloadBytes; i++) payload[8*i +: 8] = frame_model[i+1];
    flags = frame_model[FlagByteAddr];
    fs = cfg_model.failsafe_enable && ((flags & cfg_model.failsafe_mask) == 8'h00);
    for (int ch = 0; ch < ChannelCount; ch++) begin
      r.chan = ChanW'(ch);
      if (ch < PropChannels) begin
        r.raw = payload[RawW*ch +: RawW];
      end else begin
        mask = (ch == PropChannels) ? cfg_model.discrete_one_mask
                                    : cfg_model.discrete_two_mask;
        r.raw = ((flags & mask) != 8'h00) ? cfg_model.discrete_high
                                          : cfg_model.discrete_low;
      end
      r.scaled   = ScaledW'((2 * int'(r.raw)) / 3) + ScaleOffset;
      r.fs_clear = fs;
      r.last     = (ch == ChannelCount - 1);
      pending_channels.push_back(r);
    end
  endfunction

  function automatic logic [31:0] reg_readback(input logic [2:0] idx);
    case (idx)
      RegStartByte:   reg_readback = 32'(cfg_model.start_byte);
      RegFsEnable:    reg_readback = 32'(cfg_model.failsafe_enable);
      RegDiscOneMask: reg_readback = 32'(cfg_model.discrete_one_mask);
      RegDiscTwoMask: reg_readback = 32'(cfg_model.discrete_two_mask);
      RegFsMask:      reg_readback = 32'(cfg_model.failsafe_mask);
      RegDiscHigh:    reg_readback = 32'(cfg_model.discrete_high);
      RegDiscLow:     reg_readback = 32'(cfg_model.discrete_low);
      default:        reg_readback = '0;
    endcase
  endfunction

  // APB write; called at a falling edge, returns at a falling edge
  task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegStartByte:   cfg_model.start_byte        = value[7:0];
      RegFsEnable:    cfg_model.failsafe_enable   = value[0];
      RegDiscOneMask: cfg_model.discrete_one_mask = value[7:0];
      RegDiscTwoMask: cfg_model.discrete_two_mask = value[7:0];
      RegFsMask:      cfg_model.failsafe_mask     = value[7:0];
      RegDiscHigh:    cfg_model.discrete_high     = value[RawW-1:0];
      RegDiscLow:     cfg_model.discrete_low      = value[RawW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_registers();
    logic [31:0] data;
    for (int i = 0; i < NumRegs; i++) begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {3'(i), 2'b00};
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      data = prdata;
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
      if (data !== reg_readback(3'(i))) report_mismatch("register readback", data,
                                                        reg_readback(3'(i)));
    end
    settings_tested++;
  endtask

  // hand one byte to the decoder; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] rx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = rx;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_rx_byte(rx);
    bytes_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input fill_e fill);
    logic [7:0] fill_byte;
    send_byte(cfg_model.start_byte);
    for (int i = 1; i < FrameBytes; i++) begin
      case (fill)
        FillZero:  fill_byte = 8'h00;
        FillOnes:  fill_byte = 8'hFF;
        FillStart: fill_byte = cfg_model.start_byte;
        default:   fill_byte = 8'($urandom);
      endcase
      send_byte(fill_byte);
    end
  endtask

  // idle the sender and let every expected result come out
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_channels.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // mostly whole frames, some noise and truncated frames, then pad to a boundary
  task automatic run_traffic(input int unsigned budget);
    int unsigned first;
    int unsigned pick;
    int unsigned n;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        case ($urandom_range(0, 9))
          0:       send_frame(FillZero);
          1:       send_frame(FillOnes);
          2:       send_frame(FillStart);
          default: send_frame(FillRandom);
        endcase
      end else if (pick == 7) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 20);
        send_byte(cfg_model.start_byte);
        repeat (n) send_byte(8'($urandom));
      end
    end
    while (rx_pos != 0) send_byte(8'($urandom));
    wait_drained();
  endtask

  task automatic test_register_access();
    check_registers();
    // out-of-range register index: must be ignored
    set_reg(3'(NumRegs), 32'hFFFF_FFFF);
    check_registers();
  endtask

  task automatic test_directed_frame();
    logic [7:0] sb;
    sb = cfg_model.start_byte;
    // noise while waiting for the start byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sb ^ 8'h01);
    send_byte(sb);
    // start byte value inside the payload must be taken as data
    for (int i = 1; i <= PayloadBytes; i++) begin
      case (i % 3)
        0:       send_byte(sb);
        1:       send_byte(8'hFF);
        default: send_byte(8'h00);
      endcase
    end
    send_byte(8'hFF);
    // closing byte equal to the start byte: ignored, must not reopen a frame
    send_byte(sb);
    wait_drained();
  endtask

  task automatic test_extreme_low_config();
    // values wider than their registers: only the low bits are kept
    set_reg(RegStartByte,   32'hFFFF_FF00);
    set_reg(RegFsEnable,    32'hFFFF_FFFF);
    set_reg(RegDiscOneMask, 32'hFFFF_FFFF);
    set_reg(RegDiscTwoMask, 32'hFFFF_FFFF);
    set_reg(RegFsMask,      32'h0000_0080);
    set_reg(RegDiscHigh,    32'hFFFF_FFFF);
    set_reg(RegDiscLow,     32'hFFFF_F800);
    check_registers();
    send_frame(FillZero);
    send_frame(FillOnes);
    run_traffic(PhaseBytes);
  endtask

  task automatic test_extreme_high_config();
    set_reg(RegStartByte,   32'h0000_00FF);
    set_reg(RegFsEnable,    32'h0000_0001);
    set_reg(RegDiscOneMask, 32'h0000_0000);
    set_reg(RegDiscTwoMask, 32'h0000_0000);
    set_reg(RegFsMask,      32'h0000_00FF);
    set_reg(RegDiscHigh,    32'h0000_0000);
    set_reg(RegDiscLow,     32'h0000_07FF);
    check_registers();
    send_frame(FillOnes);
    send_frame(FillZero);
    run_traffic(PhaseBytes);
  endtask

  task automatic test_random_config();
    set_reg(RegStartByte,   $urandom);
    set_reg(RegFsEnable,    $urandom);
    set_reg(RegDiscOneMask, $urandom);
    set_reg(RegDiscTwoMask, $urandom);
    set_reg(RegFsMask,      $urandom);
    set_reg(RegDiscHigh,    $urandom);
    set_reg(RegDiscLow,     $urandom);
    check_registers();
    run_traffic(PhaseBytes);
  endtask

  // receiver: stall behavior switches among always ready, random and a fixed pattern
  always @(negedge clk_i) begin
    stall_count++;
    if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_count % 16 >= 12);
    endcase
  end

  always @(posedge clk_i) begin
    chan_result_t got;
    chan_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.chan     = m_axis_tuser;
      got.raw      = m_axis_tdata[10:0];
      got.scaled   = m_axis_tdata[22:11];
      got.fs_clear = m_axis_tdata[23];
      got.last     = m_axis_tlast;
      if (pending_channels.size() == 0) begin
        report_mismatch("unexpected result, channel", 32'(got.chan), 0);
      end else begin
        want = pending_channels.pop_front();
        if (got.chan !== want.chan)
          report_mismatch("channel_index", 32'(got.chan), 32'(want.chan));
        if (got.raw !== want.raw)
          report_mismatch("raw_value", 32'(got.raw), 32'(want.raw));
        if (got.scaled !== want.scaled)
          report_mismatch("scaled_value", 32'(got.scaled), 32'(want.scaled));
        if (got.fs_clear !== want.fs_clear)
          report_mismatch("failsafe_clear", 32'(got.fs_clear), 32'(want.fs_clear));
        if (got.last !== want.last)
          report_mismatch("last_channel", 32'(got.last), 32'(want.last));
      end
      channels_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LimitCycles) begin
      $display("timeout with %0d results outstanding", pending_channels.size());
      $display("sbus_frame_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_register_access();
    test_directed_frame();
    test_extreme_low_config();
    test_extreme_high_config();
    repeat (2) test_random_config();
    s_axis_tvalid = 1'b0;
    while (pending_channels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d bytes, decoded %0d frames, checked %0d channel results",
             bytes_sent, frames_decoded, channels_seen);
    $display("register settings exercised with readback: %0d", settings_tested);
    if (mismatches == 0) begin
      $display("sbus_frame_decoder regression: pass");
    end else begin
      $display("sbus_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
